FILE: hw/rtl/nearest_point_label_transfer_unit_macros.svh
// assertion macros for the nearest point label transfer unit
`ifndef NEAREST_POINT_LABEL_TRANSFER_UNIT_MACROS_SVH
`define NEAREST_POINT_LABEL_TRANSFER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define NPL_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define NPL_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/npl_pkg.sv
// shared types, constants and helpers of the nearest point label transfer unit
package npl_pkg;

    // table geometry (REF_DEPTH a power of two, at least 2 * NUM_CELLS)
    localparam int REF_DEPTH   = 1024;
    localparam int NUM_CELLS   = 4;
    localparam int CELL_DEPTH  = REF_DEPTH / NUM_CELLS;
    localparam int CELL_AW     = $clog2(CELL_DEPTH);
    localparam int CELL_BITS   = $clog2(NUM_CELLS);
    localparam int IDX_BITS    = $clog2(REF_DEPTH);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int PHASE_BITS  = CELL_BITS + 1;

    // field widths
    localparam int LABEL_BITS  = 8;
    localparam int COORD_BITS  = 16;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int SUM_BITS    = SQ_BITS + 2;
    localparam int DIST_BITS   = 36;
    localparam int OUT_LABEL_BITS = 8;
    localparam int OUT_IDX_BITS   = 10;
    localparam int S_TDATA_BITS   = 56;
    localparam int M_TDATA_BITS   = 24;
    localparam int M_PAD_BITS     = M_TDATA_BITS - OUT_LABEL_BITS - OUT_IDX_BITS;

    localparam logic [DIST_BITS-1:0] START_DIST_RESET = 36'd65536000000;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_LOADED   = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_ANSWERED = 2'd2;
    localparam logic [1:0] STATUS_EMPTY    = 2'd3;

    typedef struct packed {
        logic [LABEL_BITS-1:0] label;
        logic [COORD_BITS-1:0] z;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } npl_entry_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] z;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } npl_point_t;

    // running best handed from cell to cell
    typedef struct packed {
        logic [DIST_BITS-1:0]  sq_dist;
        logic [IDX_BITS-1:0]   idx;
        logic [LABEL_BITS-1:0] label;
    } npl_cand_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                 wr_en;
        logic [CELL_BITS-1:0] wr_sel;
        logic [CELL_AW-1:0]   wr_addr;
        npl_entry_t           wr_data;
        logic                 start;
        logic                 rd_en;
        logic [CELL_AW-1:0]   rd_addr;
        logic                 merge;
    } npl_ctrl_t;

    // magnitude of the difference of two signed coordinates
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] n;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        n = ~d + 1'b1;
        return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

endpackage

FILE: hw/rtl/npl_ram.sv
// generic single write port, registered read ram
module npl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/npl_cell.sv
// one search cell: a bank of reference points, a distance pipe and a merge stage
module npl_cell
    import npl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [CELL_BITS-1:0]  cell_id,
    input  logic [CNT_BITS-1:0]   ref_count,
    input  npl_ctrl_t             ctrl,
    input  npl_point_t            query,
    input  npl_cand_t             chain_in,
    output npl_cand_t             chain_out,
    output logic [LABEL_BITS-1:0] first_label
);

    npl_entry_t rd_entry;
    logic [IDX_BITS-1:0] rd_idx;
    logic                rd_live;

    logic                p1_vld_reg;
    logic                p1_first_reg;
    logic [IDX_BITS-1:0] p1_idx_reg;

    logic                  p2_vld_reg;
    logic                  p2_first_reg;
    logic [IDX_BITS-1:0]   p2_idx_reg;
    logic [LABEL_BITS-1:0] p2_label_reg;
    logic [SQ_BITS-1:0]    sq_x_reg;
    logic [SQ_BITS-1:0]    sq_y_reg;
    logic [SQ_BITS-1:0]    sq_z_reg;

    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] az;
    logic [SUM_BITS-1:0]   dist_sum;

    logic                  lb_vld_reg;
    logic [SUM_BITS-1:0]   lb_dist_reg;
    logic [IDX_BITS-1:0]   lb_idx_reg;
    logic [LABEL_BITS-1:0] lb_label_reg;

    npl_cand_t             chain_out_reg;
    logic [LABEL_BITS-1:0] first_label_reg;

    npl_ram #(
        .WIDTH ($bits(npl_entry_t)),
        .DEPTH (CELL_DEPTH)
    ) u_bank (
        .aclk    (aclk),
        .wr_en   (ctrl.wr_en && (ctrl.wr_sel == cell_id)),
        .wr_addr (ctrl.wr_addr),
        .wr_data (ctrl.wr_data),
        .rd_addr (ctrl.rd_addr),
        .rd_data (rd_entry)
    );

    // only entries below the fill count take part
    assign rd_idx  = {cell_id, ctrl.rd_addr};
    assign rd_live = CNT_BITS'(rd_idx) < ref_count;

    assign ax = abs_diff(rd_entry.x, query.x);
    assign ay = abs_diff(rd_entry.y, query.y);
    assign az = abs_diff(rd_entry.z, query.z);

    assign dist_sum = SUM_BITS'(sq_x_reg) + SUM_BITS'(sq_y_reg) + SUM_BITS'(sq_z_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            lb_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= ctrl.rd_en && rd_live;
            p2_vld_reg <= p1_vld_reg;
            if (ctrl.start) begin
                lb_vld_reg <= 1'b0;
            end else if (p2_vld_reg && (!lb_vld_reg || dist_sum < lb_dist_reg)) begin
                lb_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p1_idx_reg   <= rd_idx;
        p1_first_reg <= ctrl.rd_addr == '0;

        p2_idx_reg   <= p1_idx_reg;
        p2_first_reg <= p1_first_reg;
        p2_label_reg <= rd_entry.label;
        sq_x_reg     <= SQ_BITS'(ax) * SQ_BITS'(ax);
        sq_y_reg     <= SQ_BITS'(ay) * SQ_BITS'(ay);
        sq_z_reg     <= SQ_BITS'(az) * SQ_BITS'(az);

        // first strictly smaller distance wins inside the bank
        if (p2_vld_reg && (!lb_vld_reg || dist_sum < lb_dist_reg)) begin
            lb_dist_reg  <= dist_sum;
            lb_idx_reg   <= p2_idx_reg;
            lb_label_reg <= p2_label_reg;
        end

        if (p2_vld_reg && p2_first_reg) begin
            first_label_reg <= p2_label_reg;
        end

        // lower indices arrive from the left, so ties keep the incoming one
        if (ctrl.merge) begin
            if (lb_vld_reg && DIST_BITS'(lb_dist_reg) < chain_in.sq_dist) begin
                chain_out_reg.sq_dist <= DIST_BITS'(lb_dist_reg);
                chain_out_reg.idx     <= lb_idx_reg;
                chain_out_reg.label   <= lb_label_reg;
            end else begin
                chain_out_reg <= chain_in;
            end
        end
    end

    assign chain_out   = chain_out_reg;
    assign first_label = first_label_reg;

endmodule

FILE: hw/rtl/nearest_point_label_transfer_unit.sv
// top level: load and query sequencer around a chain of nearest point search cells
// load, table-full and empty-table answers: result registered from the request decode, or
//   parked in ST_HOLD while the output register is occupied; query: the result follows
//   the bank scan, the pipe drain, the cell-to-cell merge and the output register
// one item in work at a time; a new item is taken while the previous result waits at m_
// synchronous active-low reset empties the table and loads the start distance register
module nearest_point_label_transfer_unit
    import npl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    // configuration: start_distance_squared
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [DIST_BITS-1:0]    cfg_data,

    // request stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // coord_x, coord_y, coord_z, point_label
    input  logic [0:0]              s_tuser,   // req_type

    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,   // match_label, match_index, zero pad
    output logic [1:0]              m_tuser    // status
);

    `include "nearest_point_label_transfer_unit_macros.svh"

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_MERGE = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_HOLD  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_BITS-1:0]       count_reg, count_next;
    logic [DIST_BITS-1:0]      start_reg;
    npl_point_t                query_reg, query_next;
    logic [CELL_AW-1:0]        scan_addr_reg, scan_addr_next;
    logic [PHASE_BITS-1:0]     phase_reg, phase_next;

    // output register
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [1:0]                m_status_reg, m_status_next;
    logic [OUT_LABEL_BITS-1:0] m_label_reg, m_label_next;
    logic [OUT_IDX_BITS-1:0]   m_index_reg, m_index_next;

    // result parked while the output register is still occupied
    logic [1:0]                pend_status_reg, pend_status_next;
    logic [OUT_LABEL_BITS-1:0] pend_label_reg, pend_label_next;
    logic [OUT_IDX_BITS-1:0]   pend_index_reg, pend_index_next;

    // request decode
    logic                      in_xfer;
    logic                      is_load;
    logic                      table_full;
    npl_entry_t                in_entry;
    logic [1:0]                imm_status;
    logic [OUT_LABEL_BITS-1:0] imm_label;
    logic [OUT_IDX_BITS-1:0]   imm_index;
    logic                      out_free;

    npl_ctrl_t                 ctrl;
    npl_cand_t                 chain [NUM_CELLS+1];
    logic [LABEL_BITS-1:0]     first_label [NUM_CELLS];
    npl_cand_t                 final_best;

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg == ST_IDLE;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign is_load    = s_tuser[0] == REQ_LOAD;
    assign table_full = count_reg == CNT_BITS'(REF_DEPTH);

    assign in_entry.x     = s_tdata[15:0];
    assign in_entry.y     = s_tdata[31:16];
    assign in_entry.z     = s_tdata[47:32];
    assign in_entry.label = LABEL_BITS'(s_tdata[55:48]);

    // answers that need no search: stored, table full, empty table
    always_comb begin
        imm_status = STATUS_EMPTY;
        imm_label  = '0;
        imm_index  = '0;
        if (is_load) begin
            if (table_full) begin
                imm_status = STATUS_FULL;
            end else begin
                imm_status = STATUS_LOADED;
                imm_label  = OUT_LABEL_BITS'(in_entry.label);
                imm_index  = OUT_IDX_BITS'(count_reg);
            end
        end
    end

    // broadcast control for the cell chain
    always_comb begin
        ctrl.wr_en   = in_xfer && is_load && !table_full;
        ctrl.wr_sel  = count_reg[IDX_BITS-1:CELL_AW];
        ctrl.wr_addr = count_reg[CELL_AW-1:0];
        ctrl.wr_data = in_entry;
        ctrl.start   = in_xfer && !is_load && (count_reg != '0);
        ctrl.rd_en   = state_reg == ST_SCAN;
        ctrl.rd_addr = scan_addr_reg;
        ctrl.merge   = state_reg == ST_MERGE;
    end

    // seed of the chain: the start threshold, reported as entry 0 if never beaten
    assign chain[0].sq_dist = start_reg;
    assign chain[0].idx     = '0;
    assign chain[0].label   = first_label[0];

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        npl_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_id     (CELL_BITS'(k)),
            .ref_count   (count_reg),
            .ctrl        (ctrl),
            .query       (query_reg),
            .chain_in    (chain[k]),
            .chain_out   (chain[k+1]),
            .first_label (first_label[k])
        );
    end

    assign final_best = chain[NUM_CELLS];

    // sequencer
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        query_next       = query_reg;
        scan_addr_next   = scan_addr_reg;
        phase_next       = phase_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_label_next     = m_label_reg;
        m_index_next     = m_index_reg;
        pend_status_next = pend_status_reg;
        pend_label_next  = pend_label_reg;
        pend_index_next  = pend_index_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (ctrl.wr_en) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (ctrl.start) begin
                        query_next.x   = in_entry.x;
                        query_next.y   = in_entry.y;
                        query_next.z   = in_entry.z;
                        scan_addr_next = '0;
                        state_next     = ST_SCAN;
                    end else if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_status_next = imm_status;
                        m_label_next  = imm_label;
                        m_index_next  = imm_index;
                    end else begin
                        pend_status_next = imm_status;
                        pend_label_next  = imm_label;
                        pend_index_next  = imm_index;
                        state_next       = ST_HOLD;
                    end
                end
            end
            ST_SCAN: begin
                // one bank address per cycle in every cell at once
                scan_addr_next = scan_addr_reg + 1'b1;
                if (scan_addr_reg == CELL_AW'(CELL_DEPTH - 1)) begin
                    phase_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // read and square stages empty into the local best
                phase_next = phase_reg + 1'b1;
                if (phase_reg == PHASE_BITS'(1)) begin
                    phase_next = '0;
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                // the best moves one cell to the right per cycle
                phase_next = phase_reg + 1'b1;
                if (phase_reg == PHASE_BITS'(NUM_CELLS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = STATUS_ANSWERED;
                    m_label_next  = OUT_LABEL_BITS'(final_best.label);
                    m_index_next  = OUT_IDX_BITS'(final_best.idx);
                    state_next    = ST_IDLE;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = pend_status_reg;
                    m_label_next  = pend_label_reg;
                    m_index_next  = pend_index_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            start_reg    <= START_DIST_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                start_reg <= cfg_data;
            end
        end
    end

    // payload and counters
    always_ff @(posedge aclk) begin
        query_reg       <= query_next;
        scan_addr_reg   <= scan_addr_next;
        phase_reg       <= phase_next;
        m_status_reg    <= m_status_next;
        m_label_reg     <= m_label_next;
        m_index_reg     <= m_index_next;
        pend_status_reg <= pend_status_next;
        pend_label_reg  <= pend_label_next;
        pend_index_reg  <= pend_index_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {M_PAD_BITS'(0), m_index_reg, m_label_reg};

    // checks
    `NPL_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_BITS'(REF_DEPTH), "fill count beyond table depth")
    `NPL_ASSERT_NEXT(a_load_counts, aclk, aresetn, in_xfer && is_load && !table_full, count_reg == CNT_BITS'($past(count_reg) + 1'b1), "stored load did not advance fill count")
    `NPL_ASSERT_NEXT(a_done_answers, aclk, aresetn, (state_reg == ST_DONE) && out_free, m_tvalid && (m_tuser == STATUS_ANSWERED), "finished search not presented as answered")

endmodule
